### hw/rtl/aes_pkg.sv
// AES-128 package: S-box, round constants, GF helpers, round and key-step functions.
// Used by the round cell and the top level of the block encrypt core.
package aes_pkg;

  localparam int unsigned NumRounds = 10;
  localparam int unsigned RoundW    = 4;
  localparam logic [1:0]  CfgKeyHigh = 2'd0;
  localparam logic [1:0]  CfgKeyLow  = 2'd1;

  typedef logic [127:0] blk_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] rcon(input logic [RoundW-1:0] r);
    logic [7:0] v;
    case (r)
      4'd1: v = 8'h01;  4'd2: v = 8'h02;  4'd3: v = 8'h04;  4'd4: v = 8'h08;
      4'd5: v = 8'h10;  4'd6: v = 8'h20;  4'd7: v = 8'h40;  4'd8: v = 8'h80;
      4'd9: v = 8'h1b;  4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the block sits at bits 127-8i -: 8 (byte 0 most significant)
  function automatic logic [7:0] gb(input blk_t s, input int unsigned i);
    return s[127-8*i -: 8];
  endfunction

  // one key schedule step: round key r-1 -> round key r
  function automatic blk_t key_step(input blk_t k, input logic [RoundW-1:0] r);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t  = {sbox(w3[23:16]) ^ rcon(r), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // SubBytes, ShiftRows, optional MixColumns, AddRoundKey
  function automatic blk_t round_fn(input blk_t s, input blk_t k, input logic mix);
    blk_t t, m;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(r+4*c) -: 8] = sbox(gb(s, r + 4*((c + r) % 4)));
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = gb(t, 4*c); a1 = gb(t, 4*c+1); a2 = gb(t, 4*c+2); a3 = gb(t, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      m[127-32*c -: 32] = {a0 ^ al ^ xt(a0 ^ a1), a1 ^ al ^ xt(a1 ^ a2),
                           a2 ^ al ^ xt(a2 ^ a3), a3 ^ al ^ xt(a3 ^ a0)};
    end
    return (mix ? m : t) ^ k;
  endfunction

endpackage

### hw/rtl/aes_cell.sv
// One round cell: registered state and round key of one item in flight.
// Depends on aes_pkg.
module aes_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic [3:0]    rnd_i,
  input  logic          vld_i,
  input  aes_pkg::blk_t st_i,
  input  aes_pkg::blk_t key_i,
  output logic          vld_o,
  output aes_pkg::blk_t st_o,
  output aes_pkg::blk_t key_o
);
  import aes_pkg::*;

  logic vld_q;
  blk_t st_q, key_q, key_d;

  assign key_d = key_step(key_i, rnd_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q  <= round_fn(st_i, key_d, rnd_i != 4'(NumRounds));
      key_q <= key_d;
    end
  end

  assign vld_o = vld_q;
  assign st_o  = st_q;
  assign key_o = key_q;
endmodule

### hw/rtl/aes128_block_encrypt_core.sv
// AES-128 block encrypt core: key registers, input whitening, ten round cells.
// Depends on aes_pkg and aes_cell.
//
//  channel | valid       | flow ctrl   | payload
//  in      | in_valid_i  | in_stall_o  | plain_high_i, plain_low_i
//  out     | out_valid_o | out_stall_i | cipher_high_o, cipher_low_o
//  cfg     | cfg_valid_i | cfg_ready_o | cfg_index_i, cfg_data_i
//
// Stages: whitening register plus ten round cells; one item per cycle sustained
// while the output is not stalled. Each cell carries its item's round key along,
// so keys are expanded on the fly in step with the data.
// The chain advances whenever the last cell is empty or its result is taken;
// a stall on the output freezes the whole chain and is reflected at in_stall_o.
// Reset clears the valid bits and the key registers.
module aes128_block_encrypt_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] plain_high_i,
  input  logic [63:0] plain_low_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] cipher_high_o,
  output logic [63:0] cipher_low_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import aes_pkg::*;

  logic [63:0] key_hi_q, key_lo_q;
  logic        en;
  logic        vld [NumRounds+1];
  blk_t        st  [NumRounds+1];
  blk_t        rk  [NumRounds+1];
  logic        v0_q;
  blk_t        s0_q, k0_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgKeyHigh: key_hi_q <= cfg_data_i;
        CfgKeyLow:  key_lo_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // chain moves unless a finished item is held at the output
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  // initial AddRoundKey; the cipher key travels with the item
  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q <= {plain_high_i, plain_low_i} ^ {key_hi_q, key_lo_q};
      k0_q <= {key_hi_q, key_lo_q};
    end
  end

  assign vld[0] = v0_q;
  assign st[0]  = s0_q;
  assign rk[0]  = k0_q;

  for (genvar g = 0; g < NumRounds; g++) begin : g_cell
    aes_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .rnd_i (RoundW'(g + 1)),
      .vld_i (vld[g]),
      .st_i  (st[g]),
      .key_i (rk[g]),
      .vld_o (vld[g+1]),
      .st_o  (st[g+1]),
      .key_o (rk[g+1])
    );
  end

  assign out_valid_o   = vld[NumRounds];
  assign cipher_high_o = st[NumRounds][127:64];
  assign cipher_low_o  = st[NumRounds][63:0];
endmodule

### hw/rtl/aes128_block_encrypt_core_chk.sv
// Port-level checker for the AES-128 encrypt core, bound to the top level.
// Depends on nothing beyond the top-level ports.
module aes128_block_encrypt_core_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] cipher_high_o,
  input logic [63:0] cipher_low_o
);
  // stall on input only while output is held
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i)) else $error("input stall without cause");

  // held result does not change
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(cipher_high_o)
      && $stable(cipher_low_o))) else $error("held result changed");

  // a rising output valid must follow an unstalled input
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_stall_o)) else $error("result without progress");
endmodule

bind aes128_block_encrypt_core aes128_block_encrypt_core_chk u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
  .cipher_high_o(cipher_high_o), .cipher_low_o(cipher_low_o)
);

### bench/aes_checker.sv
// Scoreboard for the AES-128 block encrypt core: tracks key writes, predicts
// each ciphertext from its own cipher model and compares results in order.
// Depends on nothing beyond the port signals of the core.
module aes_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [63:0] plain_high_i,
  input  logic [63:0] plain_low_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [63:0] cipher_high_i,
  input  logic [63:0] cipher_low_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam logic [1:0] KeyHighIdx = 2'd0;
  localparam logic [1:0] KeyLowIdx  = 2'd1;

  localparam logic [7:0] SubTab [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  localparam logic [7:0] RoundConst [10] = '{
    8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36};

  logic [63:0]  key_hi_q, key_lo_q;
  logic [127:0] cipher_q [$];
  int           fails;

  function automatic logic [7:0] gf2(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // byte 0 of a block is its most significant byte
  function automatic logic [127:0] encrypt(input logic [127:0] key, input logic [127:0] blk);
    logic [7:0] rk [176];
    logic [7:0] st [16];
    logic [7:0] tmp [16];
    logic [7:0] w [4];
    logic [7:0] x, a0, a1, a2, a3, al;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127-8*i -: 8];
      st[i] = blk[127-8*i -: 8];
    end
    for (int k = 4; k < 44; k++) begin
      for (int j = 0; j < 4; j++) w[j] = rk[4*(k-1)+j];
      if ((k % 4) == 0) begin
        x    = w[0];
        w[0] = SubTab[w[1]] ^ RoundConst[k/4-1];
        w[1] = SubTab[w[2]];
        w[2] = SubTab[w[3]];
        w[3] = SubTab[x];
      end
      for (int j = 0; j < 4; j++) rk[4*k+j] = rk[4*(k-4)+j] ^ w[j];
    end
    for (int i = 0; i < 16; i++) st[i] = st[i] ^ rk[i];
    for (int rnd = 1; rnd <= 10; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) tmp[r+4*c] = SubTab[st[r+4*((c+r)%4)]];
      if (rnd < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = tmp[4*c]; a1 = tmp[4*c+1]; a2 = tmp[4*c+2]; a3 = tmp[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          tmp[4*c]   = a0 ^ al ^ gf2(a0 ^ a1);
          tmp[4*c+1] = a1 ^ al ^ gf2(a1 ^ a2);
          tmp[4*c+2] = a2 ^ al ^ gf2(a2 ^ a3);
          tmp[4*c+3] = a3 ^ al ^ gf2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) st[i] = tmp[i] ^ rk[16*rnd+i];
    end
    for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [127:0] exp_blk;
    if (!rst_ni) begin
      key_hi_q = '0;
      key_lo_q = '0;
      cipher_q.delete();
      fails    = 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        cipher_q.push_back(encrypt({key_hi_q, key_lo_q}, {plain_high_i, plain_low_i}));
      if (out_valid_i && !out_stall_i) begin
        if (cipher_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result %h %h", $time, cipher_high_i, cipher_low_i);
        end else begin
          exp_blk = cipher_q.pop_front();
          if (cipher_high_i !== exp_blk[127:64]) begin
            fails++;
            $display("%0t: cipher_high expected %h actual %h", $time, exp_blk[127:64],
                     cipher_high_i);
          end
          if (cipher_low_i !== exp_blk[63:0]) begin
            fails++;
            $display("%0t: cipher_low expected %h actual %h", $time, exp_blk[63:0],
                     cipher_low_i);
          end
        end
      end
      // key takes effect for items accepted after this edge
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == KeyHighIdx) key_hi_q = cfg_data_i;
        else if (cfg_index_i == KeyLowIdx) key_lo_q = cfg_data_i;
      end
    end
    fail_count_o = fails;
    pending_o    = cipher_q.size();
  end

endmodule

### bench/tb.sv
// Top of the AES-128 encrypt core bench: clock, reset, key writes, plaintext
// stimulus with bursty flow control, verdict. Depends on aes_pkg, aes_checker and the core.
module tb;
  import aes_pkg::*;

  localparam int WatchLimit = 5000;
  localparam int LongHold   = 400;
  localparam int Drain      = 16;   // core latency plus margin

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] plain_hi = '0, plain_lo = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] cipher_hi, cipher_lo;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  int          fail_count, pending;
  int          burst_left = 0;
  int          idle_cycles = 0;
  bit          hold_req = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  aes128_block_encrypt_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .plain_high_i(plain_hi), .plain_low_i(plain_lo),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .cipher_high_o(cipher_hi), .cipher_low_o(cipher_lo),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  aes_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .plain_high_i(plain_hi), .plain_low_i(plain_lo),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .cipher_high_i(cipher_hi), .cipher_low_i(cipher_lo),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // watchdog: cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stall density per stretch, plus one long hold on request
  initial begin
    int stretch, pct;
    forever begin
      stretch = $urandom_range(10, 80);
      case ($urandom_range(0, 3))
        0: pct = 0;
        1: pct = 20;
        2: pct = 50;
        default: pct = 85;
      endcase
      repeat (stretch) begin
        @(posedge clk);
        if (hold_req) begin
          out_stall <= 1'b1;
          repeat (LongHold) @(posedge clk);
          hold_req = 1'b0;
        end
        out_stall <= ($urandom_range(0, 99) < pct);
      end
    end
  end

  // key write, only while the core is drained; cfg_valid drops after each write
  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
    write_reg(CfgKeyHigh, hi);
    write_reg(CfgKeyLow, lo);
  endtask

  // offer one item; valid may drop in random gaps between bursts
  task automatic push_block(input logic [63:0] hi, input logic [63:0] lo);
    int gap;
    in_valid <= 1'b1;
    plain_hi <= hi;
    plain_lo <= lo;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  initial begin
    logic [63:0] kh, kl;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset key is all zeros
    push_block('0, '0);
    push_block('1, '1);
    drain();

    // standard test vector key and plaintext
    load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
    push_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    push_block('0, '0);
    push_block('1, '1);
    push_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
    push_block(64'h8000000000000000, 64'h0000000000000001);
    drain();

    // writes past the register list leave the key alone
    write_reg(2'd2, '1);
    write_reg(2'd3, 64'hdeadbeefcafef00d);
    push_block(64'h0011223344556677, 64'h8899aabbccddeeff);
    drain();

    load_key('1, '1);
    push_block('0, '0);
    push_block('1, '1);
    push_block(64'h0123456789abcdef, 64'hfedcba9876543210);
    drain();

    // only the high half changes: new key from the next item on
    write_reg(CfgKeyHigh, '0);
    push_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
    push_block(64'h0000000000000001, 64'h8000000000000000);
    drain();

    // random phases, each under its own key
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin kh = '0; kl = '0; end
        1: begin kh = '1; kl = '1; end
        2: begin kh = '1; kl = '0; end
        default: begin kh = {$urandom, $urandom}; kl = {$urandom, $urandom}; end
      endcase
      load_key(kh, kl);
      if (ph == 3) hold_req = 1'b1;  // core fills up while the sender keeps offering
      for (int n = 0; n < 240; n++)
        push_block({$urandom, $urandom}, {$urandom, $urandom});
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
